// ===== rtl/core/ray_sphere_intersect_core_assert.svh =====
// Assertion macros for the ray/sphere intersection core.
`ifndef RAY_SPHERE_INTERSECT_CORE_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RSI_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("ray/sphere core: assertion failed");
`define RSI_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ray/sphere core: assertion failed");
`else
`define RSI_ASSERT(lbl, expr)
`define RSI_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/core/rsi_pkg.sv =====
// Types, constants and helper functions of the ray/sphere intersection core.
package rsi_pkg;

	typedef enum logic [1:0] {
		CFG_CENTER_X = 2'd0,
		CFG_CENTER_Y = 2'd1,
		CFG_CENTER_Z = 2'd2,
		CFG_RADIUS   = 2'd3
	} cfg_idx_t;

	localparam int NUM_STAGES  = 16;
	localparam int SQRT_STAGES = 8;
	localparam int SQRT_STEPS  = 4;
	localparam int FIRST_SQRT  = 6;

	localparam logic [30:0] DIST_MAX   = '1;
	localparam logic [47:0] RAD_MAX    = '1;
	localparam logic [31:0] RADIUS_RST = 32'd65536;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [17:0] dx;
		logic signed [17:0] dy;
		logic signed [17:0] dz;
	} ray_t;

	typedef struct packed {
		logic [35:0] hh;
		logic [35:0] hl;
		logic [35:0] lo;
	} sq_part_t;

	// partial products of a 36-bit square, split at bit 18
	function automatic sq_part_t sq_split(logic [35:0] a);
		sq_part_t p;
		p.hh = a[35:18] * a[35:18];
		p.hl = a[35:18] * a[17:0];
		p.lo = a[17:0] * a[17:0];
		return p;
	endfunction

	// floor(a*a / 2^16) from the partial products
	function automatic logic [55:0] sq16_join(sq_part_t p);
		return (56'(p.hh) << 20) + (56'(p.hl) << 3) + 56'(p.lo[35:16]);
	endfunction

endpackage

// ===== rtl/core/ray_sphere_intersect_core.sv =====
// Ray/sphere intersection core: deep pipeline, one ray per cycle while the output is not stalled.
//
// Takes one ray per clock while in_ready is high (origin Q16.16, direction Q1.16)
// and tests it against the sphere held in the center and radius registers;
// each ray gives exactly one result, in order, from the last pipeline stage.
// The square root runs as eight pipeline stages of four bits each, with five
// stages for the projection and squares ahead of it and three for the
// distance selection and hit point behind it. Every stage holds its own valid
// bit and stalls only when the stage after it is full, so a waiting result
// does not block rays still filling the pipe. Write the sphere registers only
// while the pipeline is empty.
module ray_sphere_intersect_core
	import rsi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	input  logic signed [17:0] dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [30:0]        hit_distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        radius_q;

	logic [NUM_STAGES:1] vld_s;
	logic [NUM_STAGES:1] en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_RST[30:0];
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CENTER_X: center_x_q <= cfg_data;
				CFG_CENTER_Y: center_y_q <= cfg_data;
				CFG_CENTER_Z: center_z_q <= cfg_data;
				CFG_RADIUS:   radius_q   <= cfg_data[30:0];
				default:      ;
			endcase
		end
	end

	// stage enables: a stage loads when it is empty or its successor loads
	always_comb begin
		en[NUM_STAGES] = ~vld_s[NUM_STAGES] | out_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			en[k] = ~vld_s[k] | en[k + 1];
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_s[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= (k == 1) ? in_valid : vld_s[k - 1];
				end
			end
		end
	end

	// stage 1: vector to center
	ray_t               ray_s1;
	logic signed [32:0] lx_s1, ly_s1, lz_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ray_s1 <= '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
			lx_s1  <= 33'(center_x_q) - 33'(origin_x);
			ly_s1  <= 33'(center_y_q) - 33'(origin_y);
			lz_s1  <= 33'(center_z_q) - 33'(origin_z);
		end
	end

	// stage 2: projection products, partial squares of L, radius squared
	ray_t               ray_s2;
	logic signed [50:0] pdx_s2, pdy_s2, pdz_s2;
	sq_part_t           sqx_s2, sqy_s2, sqz_s2;
	logic [45:0]        r2_s2;
	logic [32:0]        mlx, mly, mlz;
	logic [61:0]        rr;

	assign mlx = lx_s1[32] ? 33'(-lx_s1) : lx_s1;
	assign mly = ly_s1[32] ? 33'(-ly_s1) : ly_s1;
	assign mlz = lz_s1[32] ? 33'(-lz_s1) : lz_s1;
	assign rr  = radius_q * radius_q;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ray_s2 <= ray_s1;
			pdx_s2 <= lx_s1 * ray_s1.dx;
			pdy_s2 <= ly_s1 * ray_s1.dy;
			pdz_s2 <= lz_s1 * ray_s1.dz;
			sqx_s2 <= sq_split(36'(mlx));
			sqy_s2 <= sq_split(36'(mly));
			sqz_s2 <= sq_split(36'(mlz));
			r2_s2  <= rr[61:16];
		end
	end

	// stage 3: tc rounded, L.L
	ray_t               ray_s3;
	logic signed [36:0] tc_s3;
	logic [49:0]        ll_s3;
	logic [45:0]        r2_s3;
	logic signed [52:0] tc_sum;

	assign tc_sum = 53'(pdx_s2) + 53'(pdy_s2) + 53'(pdz_s2) + 53'sd32768;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ray_s3 <= ray_s2;
			tc_s3  <= tc_sum[52:16];
			ll_s3  <= 50'(sq16_join(sqx_s2)) + 50'(sq16_join(sqy_s2))
				+ 50'(sq16_join(sqz_s2));
			r2_s3  <= r2_s2;
		end
	end

	// stage 4: partial squares of tc
	ray_t               ray_s4;
	logic signed [36:0] tc_s4;
	logic [49:0]        ll_s4;
	logic [45:0]        r2_s4;
	sq_part_t           sqt_s4;
	logic [36:0]        mtc;

	assign mtc = tc_s3[36] ? 37'(-tc_s3) : tc_s3;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ray_s4 <= ray_s3;
			tc_s4  <= tc_s3;
			ll_s4  <= ll_s3;
			r2_s4  <= r2_s3;
			sqt_s4 <= sq_split(mtc[35:0]);
		end
	end

	// stage 5: perpendicular distance, radicand
	ray_t               ray_s5;
	logic signed [36:0] tc_s5;
	logic               ok_s5;
	logic [63:0]        v_s5;
	logic signed [55:0] d2, r2e, rad;
	logic [47:0]        rad_sat;

	assign d2      = $signed({2'b00, ll_s4}) - $signed(sq16_join(sqt_s4));
	assign r2e     = $signed({10'd0, r2_s4});
	assign rad     = r2e - d2;
	assign rad_sat = (|rad[55:48]) ? RAD_MAX : rad[47:0];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ray_s5 <= ray_s4;
			tc_s5  <= tc_s4;
			ok_s5  <= (d2 <= r2e);
			v_s5   <= {rad_sat, 16'd0};
		end
	end

	// stages 6 to 13: square root, four result bits per stage
	ray_t               sq_ray_s  [SQRT_STAGES];
	logic signed [36:0] sq_tc_s   [SQRT_STAGES];
	logic               sq_ok_s   [SQRT_STAGES];
	logic [63:0]        sq_v_s    [SQRT_STAGES];
	logic [33:0]        sq_rem_s  [SQRT_STAGES];
	logic [31:0]        sq_root_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		ray_t               ray_in;
		logic signed [36:0] tc_in;
		logic               ok_in;
		logic [63:0]        v_in;
		logic [33:0]        rem_in, rem_out;
		logic [31:0]        root_in, root_out;

		if (k == 0) begin : g_first
			assign ray_in  = ray_s5;
			assign tc_in   = tc_s5;
			assign ok_in   = ok_s5;
			assign v_in    = v_s5;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign ray_in  = sq_ray_s[k - 1];
			assign tc_in   = sq_tc_s[k - 1];
			assign ok_in   = sq_ok_s[k - 1];
			assign v_in    = sq_v_s[k - 1];
			assign rem_in  = sq_rem_s[k - 1];
			assign root_in = sq_root_s[k - 1];
		end

		always_comb begin
			logic [34:0] w;
			logic [34:0] trial;
			int          j;
			rem_out  = rem_in;
			root_out = root_in;
			for (int m = 0; m < SQRT_STEPS; m++) begin
				j     = k * SQRT_STEPS + m;
				w     = {rem_out[32:0], v_in[63 - 2 * j -: 2]};
				trial = {1'b0, root_out, 2'b01};
				if (w >= trial) begin
					rem_out  = 34'(w - trial);
					root_out = {root_out[30:0], 1'b1};
				end else begin
					rem_out  = w[33:0];
					root_out = {root_out[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[FIRST_SQRT + k]) begin
				sq_ray_s[k]  <= ray_in;
				sq_tc_s[k]   <= tc_in;
				sq_ok_s[k]   <= ok_in;
				sq_v_s[k]    <= v_in;
				sq_rem_s[k]  <= rem_out;
				sq_root_s[k] <= root_out;
			end
		end
	end

	// stage 14: pick the nearest positive distance
	ray_t               ray_s14;
	logic signed [37:0] t_s14;
	logic               hit_s14;
	logic [30:0]        dist_s14;
	logic signed [37:0] t1, t2, tsel;

	assign t1   = 38'(sq_tc_s[SQRT_STAGES - 1]) - $signed({6'd0, sq_root_s[SQRT_STAGES - 1]});
	assign t2   = 38'(sq_tc_s[SQRT_STAGES - 1]) + $signed({6'd0, sq_root_s[SQRT_STAGES - 1]});
	assign tsel = (t1 > 0) ? t1 : t2;

	always_ff @(posedge clk) begin
		if (en[14]) begin
			ray_s14  <= sq_ray_s[SQRT_STAGES - 1];
			t_s14    <= tsel;
			hit_s14  <= sq_ok_s[SQRT_STAGES - 1] && ((t1 > 0) || (t2 > 0));
			dist_s14 <= (tsel > $signed({7'd0, DIST_MAX})) ? DIST_MAX : tsel[30:0];
		end
	end

	// stage 15: direction times distance, split products
	ray_t               ray_s15;
	logic               hit_s15;
	logic [30:0]        dist_s15;
	logic signed [37:0] phx_s15, phy_s15, phz_s15;
	logic signed [37:0] plx_s15, ply_s15, plz_s15;
	logic signed [19:0] thi, tlo;

	assign thi = $signed({1'b0, t_s14[37:19]});
	assign tlo = $signed({1'b0, t_s14[18:0]});

	always_ff @(posedge clk) begin
		if (en[15]) begin
			ray_s15  <= ray_s14;
			hit_s15  <= hit_s14;
			dist_s15 <= dist_s14;
			phx_s15  <= ray_s14.dx * thi;
			phy_s15  <= ray_s14.dy * thi;
			phz_s15  <= ray_s14.dz * thi;
			plx_s15  <= ray_s14.dx * tlo;
			ply_s15  <= ray_s14.dy * tlo;
			plz_s15  <= ray_s14.dz * tlo;
		end
	end

	function automatic logic signed [31:0] hit_coord(logic signed [31:0] o,
		logic signed [37:0] ph, logic signed [37:0] pl);
		logic signed [56:0] prod;
		logic signed [41:0] sum;
		prod = (57'(ph) <<< 19) + 57'(pl) + 57'sd32768;
		sum  = 42'(o) + 42'($signed(prod[56:16]));
		if (sum > 42'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (sum < -42'sd2147483648) begin
			return 32'sh80000000;
		end
		return sum[31:0];
	endfunction

	// stage 16: hit point, output register
	logic               hit_s16;
	logic [30:0]        dist_s16;
	logic signed [31:0] px_s16, py_s16, pz_s16;

	always_ff @(posedge clk) begin
		if (en[16]) begin
			hit_s16  <= hit_s15;
			dist_s16 <= hit_s15 ? dist_s15 : '0;
			px_s16   <= hit_s15 ? hit_coord(ray_s15.ox, phx_s15, plx_s15) : '0;
			py_s16   <= hit_s15 ? hit_coord(ray_s15.oy, phy_s15, ply_s15) : '0;
			pz_s16   <= hit_s15 ? hit_coord(ray_s15.oz, phz_s15, plz_s15) : '0;
		end
	end

	assign hit          = hit_s16;
	assign hit_distance = dist_s16;
	assign point_x      = px_s16;
	assign point_y      = py_s16;
	assign point_z      = pz_s16;

`include "ray_sphere_intersect_core_assert.svh"

	`RSI_ASSERT(a_miss_zero, !(out_valid && !hit) || (hit_distance == '0 && point_x == '0 && point_y == '0 && point_z == '0))
	`RSI_ASSERT(a_hit_dist, !(out_valid && hit) || (hit_distance != '0))
	`RSI_ASSERT_NEXT(a_enter, in_valid && in_ready, vld_s[1])
	`RSI_ASSERT(a_empty_ready, (vld_s != '0) || in_ready)

endmodule
